### rtl/dds_pkg.sv
`timescale 1ns / 1ps

package dds_pkg;

  localparam int unsigned ACC_BITS  = 24;
  localparam int unsigned IDX_BITS  = 8;
  localparam int unsigned INC_BITS  = 24;
  localparam int unsigned CFG_BITS  = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [7:0] SAMPLE_MID  = 8'h80;
  localparam logic [7:0] SAMPLE_HIGH = 8'hFF;
  localparam logic [7:0] SAMPLE_LOW  = 8'h00;

  localparam logic [2:0] MODE_RESET = 3'd0;
  localparam logic [7:0] DUTY_RESET = 8'd128;
  localparam logic [INC_BITS-1:0] INC_RESET = INC_BITS'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_DUTY = 2'd1,
    CFG_INC  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_SINE     = 3'd0,
    MODE_SQUARE   = 3'd1,
    MODE_TRIANGLE = 3'd2,
    MODE_SAW_UP   = 3'd3,
    MODE_SAW_DOWN = 3'd4,
    MODE_CONST    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PHASE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] x;
    logic [8:0] d;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] q;
    logic       rem_nz;
  } div_rsp_t;

  localparam logic [7:0] SINE_HALF [0:128] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
    8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
    8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd17,  8'd19,  8'd20,
    8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd36,
    8'd38,  8'd40,  8'd42,  8'd45,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124,
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255
  };

  function automatic logic [7:0] sine_at(input logic [7:0] p);
    logic [7:0] k;
    k = (p > 8'd128) ? 8'(9'd256 - {1'b0, p}) : p;
    return SINE_HALF[k];
  endfunction

endpackage

### rtl/dds_in_if.sv
`timescale 1ns / 1ps

interface dds_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

### rtl/dds_out_if.sv
`timescale 1ns / 1ps

interface dds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic [7:0] phase_index;

  modport source (output valid, output sample, output phase_index, input ready);
  modport sink (input valid, input sample, input phase_index, output ready);
endinterface

### rtl/dds_div.sv
`timescale 1ns / 1ps

module dds_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dds_pkg::div_req_t  req,
  output dds_pkg::div_rsp_t  rsp
);
  import dds_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]           rem_r, rem_nxt;
  logic [8:0]           d_r, d_nxt;
  logic [7:0]           q_r, q_nxt;
  logic [9:0]           shifted;
  logic [9:0]           diff;
  logic                 take;

  // restoring step: the quotient of (x*256)/d where x < d
  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, d_r};
    take     = (shifted >= {1'b0, d_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, req.x};
      d_nxt    = req.d;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = take ? diff[8:0] : shifted[8:0];
      q_nxt   = {q_r[6:0], take};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.q      = q_r;
  assign rsp.rem_nz = (rem_r != '0);

endmodule

### rtl/dds_waveform_generator_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// in_ch     in   valid / ready    advance
// out_ch    out  valid / ready    sample[7:0], phase_index[7:0]
// cfg_*     in   cfg_we           cfg_index[1:0], cfg_wdata[23:0]
//
// One item at a time, taken only in the idle state; triangle items also pass
// through the 8-step divider, and the divide state holds while it is busy.
// A finished result sits in the output register; the next item is taken
// meanwhile, and its result waits for that register to drain.
// Synchronous active-low reset clears the accumulator and output valid, and
// sets state, mode, duty and increment to their reset values.

module dds_waveform_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  dds_in_if.sink                             in_ch,
  dds_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dds_pkg::CFG_BITS-1:0]       cfg_wdata
);
  import dds_pkg::*;

  state_t              state_r, state_nxt;
  logic [2:0]          mode_r;
  logic [7:0]          duty_r;
  logic [INC_BITS-1:0] inc_r;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [7:0]          p_r;
  logic                out_valid_r;
  logic [7:0]          out_sample_r;
  logic [7:0]          out_phase_r;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic [IDX_BITS+7:0] idx_ext;
  logic [7:0]          p_now;
  logic                rising;
  logic [8:0]          up;
  logic [7:0]          tri_val;
  logic [7:0]          sample;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  dds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_ext  = {acc_r[ACC_BITS-1 -: IDX_BITS], 8'b0};
  assign p_now    = idx_ext[IDX_BITS+7 -: 8];
  assign acc_nxt  = (in_fire && in_ch.advance) ? acc_r + ACC_BITS'(inc_r) : acc_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_PHASE;
      S_PHASE: state_nxt = (mode_t'(mode_r) == MODE_TRIANGLE) ? S_DIV : S_DONE;
      S_DIV:   if (!div_rsp.busy) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_PHASE: div_req.start = (mode_t'(mode_r) == MODE_TRIANGLE);
      S_DIV:   ;
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  // divide operands from the phase latched in S_PHASE's cycle
  always_comb begin
    if (p_now < duty_r) begin
      div_req.x = p_now;
      div_req.d = {1'b0, duty_r};
    end else begin
      div_req.x = p_now - duty_r;
      div_req.d = 9'd256 - {1'b0, duty_r};
    end
  end

  always_comb begin
    rising  = (p_r < duty_r);
    up      = {1'b0, div_rsp.q} + {8'b0, div_rsp.rem_nz};
    tri_val = rising ? div_rsp.q
                     : (up > 9'd255) ? SAMPLE_LOW : 8'(9'd255 - up);
    case (mode_t'(mode_r))
      MODE_SINE:     sample = sine_at(p_r);
      MODE_SQUARE:   sample = rising ? SAMPLE_HIGH : SAMPLE_LOW;
      MODE_TRIANGLE: sample = tri_val;
      MODE_SAW_UP:   sample = p_r;
      MODE_SAW_DOWN: sample = SAMPLE_HIGH - p_r;
      default:       sample = SAMPLE_MID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_RESET;
      duty_r      <= DUTY_RESET;
      inc_r       <= INC_RESET;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MODE: mode_r <= cfg_wdata[2:0];
          CFG_DUTY: duty_r <= cfg_wdata[7:0];
          CFG_INC:  inc_r  <= cfg_wdata[INC_BITS-1:0];
          default:  ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == S_PHASE) begin
      p_r <= p_now;
    end
    if (out_load) begin
      out_sample_r <= sample;
      out_phase_r  <= p_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample      = out_sample_r;
  assign out_ch.phase_index = out_phase_r;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide state");

  a_accept_to_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PHASE))
    else $error("accepted item did not enter phase state");

  a_acc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_ch.advance) |=> $stable(acc_r))
    else $error("accumulator moved without an advancing item");

  a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not return to idle");

endmodule

### sim/tb_dds_waveform_generator_top.sv
`timescale 1ns / 1ps

module tb_dds_waveform_generator_top;
  import dds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_TICKS = 1650;
  localparam int unsigned SETTLE_CYCLES = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam logic [7:0] HALF_SINE [0:128] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
    8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
    8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd17,  8'd19,  8'd20,
    8'd22,  8'd24,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd36,
    8'd38,  8'd40,  8'd42,  8'd45,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124,
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255
  };

  typedef struct packed {
    logic [7:0] sample;
    logic [7:0] phase_index;
  } dac_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;

  dds_in_if in_ch ();
  dds_out_if out_ch ();

  dds_waveform_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [2:0] wave_mode;
  logic [7:0] duty;
  logic [INC_BITS-1:0] phase_step;
  logic [ACC_BITS-1:0] phase_acc;

  bit tick_queue[$];
  dac_word_t expected_words[$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned src_gap;
  int unsigned snk_stall;
  int unsigned mismatches;
  int unsigned cycle_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] wave_value(logic [7:0] p);
    int unsigned span;
    int unsigned num;
    int unsigned up;
    logic [7:0] k;
    case (wave_mode)
      MODE_SINE: begin
        k = (p > 8'd128) ? 8'(9'd256 - {1'b0, p}) : p;
        return HALF_SINE[k];
      end
      MODE_SQUARE: return (p < duty) ? 8'hFF : 8'h00;
      MODE_TRIANGLE: begin
        if (p < duty) return 8'((int'(p) * 256) / int'(duty));
        span = 256 - int'(duty);
        num = (int'(p) - int'(duty)) * 256;
        up = (num + span - 1) / span;
        if (up > 255) up = 255;
        return 8'(255 - up);
      end
      MODE_SAW_UP: return p;
      MODE_SAW_DOWN: return 8'(255 - int'(p));
      default: return 8'h80;
    endcase
  endfunction

  function automatic void step_phase(bit adv);
    dac_word_t w;
    if (adv) phase_acc = phase_acc + ACC_BITS'(phase_step);
    w.phase_index = phase_acc[ACC_BITS-1 -: 8];
    w.sample = wave_value(w.phase_index);
    expected_words.push_back(w);
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.advance <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) step_phase(in_ch.advance);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
          in_ch.advance <= 1'($urandom);
        end else if (tick_queue.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.advance <= tick_queue.pop_front();
          src_gap = pick_gap(src_idle_pct);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dac_word_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected item: sample %0d phase_index %0d",
                 out_ch.sample, out_ch.phase_index);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.sample !== w.sample) begin
            $error("sample: expected %0d, actual %0d", w.sample, out_ch.sample);
            mismatches++;
          end
          if (out_ch.phase_index !== w.phase_index) begin
            $error("phase_index: expected %0d, actual %0d",
                   w.phase_index, out_ch.phase_index);
            mismatches++;
          end
        end
      end
      if (snk_stall != 0) begin
        snk_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        snk_stall = pick_gap(snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_ch.valid || expected_words.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MODE: wave_mode = value[2:0];
      CFG_DUTY: duty = value[7:0];
      CFG_INC: phase_step = value[INC_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_wave(logic [2:0] mode, logic [7:0] d, logic [INC_BITS-1:0] inc);
    write_reg(CFG_MODE, {21'($urandom), mode});
    write_reg(CFG_DUTY, {16'($urandom), d});
    write_reg(CFG_INC, inc);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_ticks(int unsigned n, int unsigned hold_pct);
    repeat (n) tick_queue.push_back($urandom_range(99) >= hold_pct);
    wait_idle();
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] d;
    logic [INC_BITS-1:0] inc;
    int unsigned sent;
    int unsigned n;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.advance = 1'b0;
    out_ch.ready = 1'b0;
    wave_mode = MODE_SINE;
    duty = 8'd128;
    phase_step = INC_BITS'(1000);
    phase_acc = '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    mismatches = 0;
    cycle_count = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    wait_idle();

    set_wave(MODE_SINE, 8'd128, 24'h400000);
    queue_ticks(4, 0);
    set_wave(MODE_SQUARE, 8'd255, 24'hFFFFFF);
    queue_ticks(2, 0);
    set_wave(MODE_TRIANGLE, 8'd1, 24'h7F0000);
    queue_ticks(3, 0);
    set_wave(MODE_TRIANGLE, 8'd255, 24'hFF0000);
    queue_ticks(2, 0);
    set_wave(MODE_TRIANGLE, 8'd0, 24'h330000);
    queue_ticks(2, 0);
    set_wave(MODE_SQUARE, 8'd0, 24'h000000);
    queue_ticks(1, 0);
    foreach (HALF_SINE[i]) if (i < 5) begin
      case (i)
        0: mode = MODE_SAW_UP;
        1: mode = MODE_SAW_DOWN;
        2: mode = MODE_CONST;
        3: mode = MODE_SPARE_A;
        default: mode = MODE_SPARE_B;
      endcase
      set_wave(mode, 8'd77, 24'h5A5A5A);
      queue_ticks(1, 0);
    end

    // spare index must leave every register alone
    write_reg(CFG_SPARE, 24'hFFFFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_ticks(2, 0);

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      case ($urandom_range(9))
        0: mode = 3'($urandom_range(7, 6));
        default: mode = 3'($urandom_range(5));
      endcase
      case ($urandom_range(7))
        0: d = 8'd0;
        1: d = 8'd1;
        2: d = 8'd255;
        default: d = 8'($urandom);
      endcase
      case ($urandom_range(7))
        0: inc = '0;
        1: inc = 24'hFFFFFF;
        2: inc = INC_BITS'($urandom_range(65535));
        3: inc = INC_BITS'($urandom_range(7, 1)) << 16;
        default: inc = INC_BITS'($urandom);
      endcase
      set_wave(mode, d, inc);
      src_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
      snk_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
      n = $urandom_range(80, 20);
      queue_ticks(n, $urandom_range(30));
      sent += n;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
